@@ sv/xsm_pkg.sv @@
// ----------------------------------------------------------------------------
// xsm_pkg
// Shared types, codes and constants of the XY spin Metropolis update block.
// ----------------------------------------------------------------------------
package xsm_pkg;

    localparam int MAX_SIDE_DEF  = 16;
    localparam int SPIN_FRAC_DEF = 14;

    localparam int CMD_W   = 2;
    localparam int COORD_W = 4;
    localparam int SIDE_W  = 5;
    localparam int SPIN_W  = 16;
    localparam int DRAW_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd2;

    localparam logic [SIDE_W-1:0] SIDE_RST  = 5'd16;
    localparam logic [15:0]       ANGLE_RST = 16'd1638;
    localparam logic [15:0]       BETA_RST  = 16'd128;

    localparam int PI_Q16      = 205887;
    localparam int HALF_PI_Q16 = 102944;
    localparam int GAIN_Q30    = 652032874;
    localparam int LN2_Q16     = 45426;

    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] r;
        unique case (i)
            4'd0:    r = 16'd51472;
            4'd1:    r = 16'd30386;
            4'd2:    r = 16'd16055;
            4'd3:    r = 16'd8150;
            4'd4:    r = 16'd4091;
            4'd5:    r = 16'd2047;
            4'd6:    r = 16'd1024;
            4'd7:    r = 16'd512;
            4'd8:    r = 16'd256;
            4'd9:    r = 16'd128;
            4'd10:   r = 16'd64;
            4'd11:   r = 16'd32;
            4'd12:   r = 16'd16;
            4'd13:   r = 16'd8;
            4'd14:   r = 16'd4;
            default: r = 16'd2;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [COORD_W-1:0]        coord_x;
        logic [COORD_W-1:0]        coord_y;
        logic [COORD_W-1:0]        coord_z;
        logic signed [SPIN_W-1:0]  spin_in_x;
        logic signed [SPIN_W-1:0]  spin_in_y;
        logic [DRAW_W-1:0]         draw_angle;
        logic [DRAW_W-1:0]         draw_accept;
    } xsm_req_t;

    typedef struct packed {
        logic                      status;
        logic                      accepted;
        logic signed [SPIN_W-1:0]  spin_out_x;
        logic signed [SPIN_W-1:0]  spin_out_y;
    } xsm_rsp_t;

    typedef enum logic [3:0] {
        OP_IDLE   = 4'd0,
        OP_CLEAR  = 4'd1,
        OP_READ   = 4'd2,
        OP_THETA  = 4'd3,
        OP_ROT    = 4'd4,
        OP_GAIN   = 4'd5,
        OP_DOT    = 4'd6,
        OP_BETA   = 4'd7,
        OP_LOGI   = 4'd8,
        OP_LOG    = 4'd9,
        OP_LN     = 4'd10,
        OP_DECIDE = 4'd11,
        OP_WRITE  = 4'd12,
        OP_DONE   = 4'd13
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic [4:0]  step;
        logic        load_in;
        logic        load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic is_update;
        logic is_write;
        logic clear_done;
    } dp_stat_t;

endpackage

@@ sv/xsm_stream_if.sv @@
// ----------------------------------------------------------------------------
// xsm_stream_if
// Valid/ready item channel with a typed payload.
// ----------------------------------------------------------------------------
interface xsm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/xsm_cfg_if.sv @@
// ----------------------------------------------------------------------------
// xsm_cfg_if
// Register write channel: index and data under valid/ready.
// ----------------------------------------------------------------------------
interface xsm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [xsm_pkg::CFG_IDX_W-1:0]   index;
    logic [xsm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/xsm_ram.sv @@
// ----------------------------------------------------------------------------
// xsm_ram
// Single-port RAM, one read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module xsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ sv/xsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// xsm_ctrl
// Sequencer: steps the datapath through clear, read, rotate, energy, accept and write.
// ----------------------------------------------------------------------------
module xsm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output xsm_pkg::dp_cmd_t  cmd,
    input  xsm_pkg::dp_stat_t stat
);
    import xsm_pkg::*;

    typedef enum logic [13:0] {
        ST_CLEAR  = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_READ   = 14'b00000000000100,
        ST_THETA  = 14'b00000000001000,
        ST_ROT    = 14'b00000000010000,
        ST_GAIN   = 14'b00000000100000,
        ST_DOT    = 14'b00000001000000,
        ST_BETA   = 14'b00000010000000,
        ST_LOGI   = 14'b00000100000000,
        ST_LOG    = 14'b00001000000000,
        ST_LN     = 14'b00010000000000,
        ST_DECIDE = 14'b00100000000000,
        ST_WRITE  = 14'b01000000000000,
        ST_DONE   = 14'b10000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic [4:0] last;
    dp_op_t     op;
    logic       out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_CLEAR:  begin op = OP_CLEAR;  last = 5'd0;  end
            ST_IDLE:   begin op = OP_IDLE;   last = 5'd0;  end
            ST_READ:   begin op = OP_READ;   last = 5'd7;  end
            ST_THETA:  begin op = OP_THETA;  last = 5'd1;  end
            ST_ROT:    begin op = OP_ROT;    last = 5'd15; end
            ST_GAIN:   begin op = OP_GAIN;   last = 5'd5;  end
            ST_DOT:    begin op = OP_DOT;    last = 5'd3;  end
            ST_BETA:   begin op = OP_BETA;   last = 5'd3;  end
            ST_LOGI:   begin op = OP_LOGI;   last = 5'd0;  end
            ST_LOG:    begin op = OP_LOG;    last = 5'd31; end
            ST_LN:     begin op = OP_LN;     last = 5'd0;  end
            ST_DECIDE: begin op = OP_DECIDE; last = 5'd0;  end
            ST_WRITE:  begin op = OP_WRITE;  last = 5'd0;  end
            default:   begin op = OP_DONE;   last = 5'd0;  end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = (step_reg == last) ? 5'd0 : step_reg + 5'd1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = stat.in_range ? ST_READ : ST_DONE;
                end
            end
            ST_READ:
            begin
                if (step_reg == last)
                begin
                    priority if (stat.is_update)
                    begin
                        state_next = ST_THETA;
                    end
                    else if (stat.is_write)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_THETA:  if (step_reg == last) state_next = ST_ROT;
            ST_ROT:    if (step_reg == last) state_next = ST_GAIN;
            ST_GAIN:   if (step_reg == last) state_next = ST_DOT;
            ST_DOT:    if (step_reg == last) state_next = ST_BETA;
            ST_BETA:   if (step_reg == last) state_next = ST_LOGI;
            ST_LOGI:   state_next = ST_LOG;
            ST_LOG:    if (step_reg == last) state_next = ST_LN;
            ST_LN:     state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_DONE;
            default:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        cmd.op       = op;
        cmd.step     = step_reg;
        cmd.load_in  = (state_reg == ST_IDLE) && req_valid;
        cmd.load_out = (state_reg == ST_DONE) && out_free;
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= 5'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end
endmodule

@@ sv/xsm_dp.sv @@
// ----------------------------------------------------------------------------
// xsm_dp
// Datapath: spin store, neighbor sum, CORDIC, shared multiplier, log2 unit.
// ----------------------------------------------------------------------------
module xsm_dp #(
    parameter int MAX_SIDE       = xsm_pkg::MAX_SIDE_DEF,
    parameter int SPIN_FRAC_BITS = xsm_pkg::SPIN_FRAC_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  xsm_pkg::dp_cmd_t                  cmd,
    output xsm_pkg::dp_stat_t                 stat,
    input  xsm_pkg::xsm_req_t                 req_data,
    input  logic                              cfg_valid,
    input  logic [xsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [xsm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output xsm_pkg::xsm_rsp_t                 rsp_data
);
    import xsm_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int IDXW  = $clog2(DEPTH);
    localparam int XW    = 36;
    localparam int AW    = 68;
    localparam int SH    = 2 * SPIN_FRAC_BITS - 24;
    localparam int XS_R  = (SH >= 0) ? SH : 0;
    localparam int XS_L  = (SH < 0) ? -SH : 0;
    localparam logic [15:0] RST_X = 16'((64'd1 << SPIN_FRAC_BITS) & 64'hFFFF);

    function automatic logic [IDXW-1:0] site(input logic [4:0] a, input logic [4:0] b,
                                             input logic [4:0] c);
        return IDXW'(a) * IDXW'(MAX_SIDE * MAX_SIDE) + IDXW'(b) * IDXW'(MAX_SIDE)
             + IDXW'(c);
    endfunction

    function automatic logic signed [XW-1:0] rnd_shr(input logic signed [XW-1:0] v,
                                                     input logic [3:0] n);
        logic signed [XW-1:0] w;
        w = v + signed'(XW'((64'd1 << n) >> 1));
        return w >>> n;
    endfunction

    function automatic logic signed [15:0] rnd_sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r;
        r = (v + (AW'(1) <<< 45)) >>> 46;
        if (r > 32767)
        begin
            return 16'sh7FFF;
        end
        else if (r < -32768)
        begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    // configuration and control registers
    logic [SIDE_W-1:0] side_reg;
    logic [15:0]       angle_reg, beta_reg;
    logic [IDXW-1:0]   clr_reg;

    // payload registers
    xsm_req_t              rq_reg;
    logic signed [15:0]    ox_reg, oy_reg, tx_reg, ty_reg;
    logic signed [18:0]    sx_reg, sy_reg;
    logic signed [XW-1:0]  cx_reg, cy_reg;
    logic signed [20:0]    z_reg;
    logic signed [63:0]    prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [39:0]    de_reg;
    logic [63:0]           xs_reg;
    logic [30:0]           m_reg;
    logic [15:0]           frac_reg;
    logic [3:0]            p_reg;
    logic                  accf_reg, res_err_reg, res_acc_reg;
    logic signed [15:0]    res_x_reg, res_y_reg;
    xsm_rsp_t              rsp_reg;

    logic [4:0]            side_eff, cx5, cy5, cz5, ix5, iy5, iz5;
    logic [4:0]            xm, xp, ym, yp, zm, zp;
    logic [IDXW-1:0]       center, addr;
    logic                  we;
    logic [31:0]           wdata, rdata;
    logic signed [15:0]    rd_x, rd_y;
    logic signed [31:0]    mul_a, mul_b;
    logic                  wr_spin;

    assign rsp_data = rsp_reg;

    // site geometry
    always_comb
    begin
        side_eff = ({2'b0, side_reg} > 7'(MAX_SIDE)) ? 5'(MAX_SIDE) : side_reg;
        ix5 = {1'b0, req_data.coord_x};
        iy5 = {1'b0, req_data.coord_y};
        iz5 = {1'b0, req_data.coord_z};
        cx5 = {1'b0, rq_reg.coord_x};
        cy5 = {1'b0, rq_reg.coord_y};
        cz5 = {1'b0, rq_reg.coord_z};
        xm = (cx5 == 5'd0) ? side_eff - 5'd1 : cx5 - 5'd1;
        xp = (cx5 + 5'd1 == side_eff) ? 5'd0 : cx5 + 5'd1;
        ym = (cy5 == 5'd0) ? side_eff - 5'd1 : cy5 - 5'd1;
        yp = (cy5 + 5'd1 == side_eff) ? 5'd0 : cy5 + 5'd1;
        zm = (cz5 == 5'd0) ? side_eff - 5'd1 : cz5 - 5'd1;
        zp = (cz5 + 5'd1 == side_eff) ? 5'd0 : cz5 + 5'd1;
        center = site(cx5, cy5, cz5);
        stat.in_range   = (ix5 < side_eff) && (iy5 < side_eff) && (iz5 < side_eff);
        stat.is_update  = (rq_reg.cmd == CMD_UPDATE);
        stat.is_write   = (rq_reg.cmd == CMD_WRITE);
        stat.clear_done = (clr_reg == IDXW'(DEPTH - 1));
    end

    // spin store port
    always_comb
    begin
        wr_spin = stat.is_write || (stat.is_update && accf_reg);
        we    = 1'b0;
        addr  = center;
        wdata = stat.is_write ? {rq_reg.spin_in_y, rq_reg.spin_in_x} : {ty_reg, tx_reg};
        unique case (cmd.op)
            OP_CLEAR:
            begin
                we    = 1'b1;
                addr  = clr_reg;
                wdata = {16'd0, RST_X};
            end
            OP_READ:
            begin
                unique case (cmd.step[2:0])
                    3'd1:    addr = site(xm, cy5, cz5);
                    3'd2:    addr = site(xp, cy5, cz5);
                    3'd3:    addr = site(cx5, ym, cz5);
                    3'd4:    addr = site(cx5, yp, cz5);
                    3'd5:    addr = site(cx5, cy5, zm);
                    3'd6:    addr = site(cx5, cy5, zp);
                    default: addr = center;
                endcase
            end
            OP_WRITE:
            begin
                we = wr_spin;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    xsm_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign rd_x = signed'(rdata[15:0]);
    assign rd_y = signed'(rdata[31:16]);

    // shared multiplier operands
    logic signed [17:0] u_ang;
    logic signed [17:0] dxo, dyo;
    logic [20:0]        ln_arg;

    always_comb
    begin
        u_ang  = signed'({1'b0, rq_reg.draw_angle, 1'b0}) - 18'sd65536;
        dxo    = {{2{tx_reg[15]}}, tx_reg} - {{2{ox_reg[15]}}, ox_reg};
        dyo    = {{2{ty_reg[15]}}, ty_reg} - {{2{oy_reg[15]}}, oy_reg};
        ln_arg = 21'd1048576 - {1'b0, p_reg, frac_reg};
        mul_a  = 32'sd0;
        mul_b  = 32'sd0;
        unique case (cmd.op)
            OP_THETA:
            begin
                mul_a = {{14{u_ang[17]}}, u_ang};
                mul_b = {16'd0, angle_reg};
            end
            OP_GAIN:
            begin
                mul_b = 32'(GAIN_Q30);
                unique case (cmd.step)
                    5'd0:    mul_a = {14'd0, cx_reg[17:0]};
                    5'd1:    mul_a = {{14{cx_reg[XW-1]}}, cx_reg[XW-1:18]};
                    5'd2:    mul_a = {14'd0, cy_reg[17:0]};
                    default: mul_a = {{14{cy_reg[XW-1]}}, cy_reg[XW-1:18]};
                endcase
            end
            OP_DOT:
            begin
                if (cmd.step == 5'd0)
                begin
                    mul_a = {{14{dxo[17]}}, dxo};
                    mul_b = {{13{sx_reg[18]}}, sx_reg};
                end
                else
                begin
                    mul_a = {{14{dyo[17]}}, dyo};
                    mul_b = {{13{sy_reg[18]}}, sy_reg};
                end
            end
            OP_BETA:
            begin
                mul_b = {16'd0, beta_reg};
                if (cmd.step == 5'd0)
                begin
                    mul_a = {14'd0, de_reg[17:0]};
                end
                else
                begin
                    mul_a = {{10{de_reg[39]}}, de_reg[39:18]};
                end
            end
            OP_LOG:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            OP_LN:
            begin
                mul_a = {11'd0, ln_arg};
                mul_b = 32'(LN2_Q16);
            end
            default:
            begin
                mul_a = 32'sd0;
            end
        endcase
    end

    // arithmetic steps
    logic signed [AW-1:0]  pe;
    logic signed [63:0]    t_sum;
    logic signed [17:0]    theta;
    logic signed [20:0]    z0, zn;
    logic signed [16:0]    v0x, v0y;
    logic                  neg;
    logic signed [XW-1:0]  ddx, ddy;
    logic [32:0]           m2;
    logic [3:0]            pf;
    logic [AW-1:0]         acc_u;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        pe    = {{4{prod_reg[63]}}, prod_reg};
        t_sum = prod_reg + 64'sd32768;
        theta = t_sum[33:16];
        z0    = 21'sd0 - {{1{theta[17]}}, theta, 2'b00};
        neg   = 1'b0;
        zn    = z0;
        if (z0 > 21'sd102944)
        begin
            zn  = z0 - 21'(PI_Q16);
            neg = 1'b1;
        end
        else if (z0 < -21'sd102944)
        begin
            zn  = z0 + 21'(PI_Q16);
            neg = 1'b1;
        end
        v0x = neg ? -{ox_reg[15], ox_reg} : {ox_reg[15], ox_reg};
        v0y = neg ? -{oy_reg[15], oy_reg} : {oy_reg[15], oy_reg};
        ddx = rnd_shr(cy_reg, cmd.step[3:0]);
        ddy = rnd_shr(cx_reg, cmd.step[3:0]);
        m2  = prod_reg[62:30];
        pf  = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (rq_reg.draw_accept[i])
            begin
                pf = 4'(i);
            end
        end
        acc_u = acc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            rq_reg      <= req_data;
            res_err_reg <= !stat.in_range;
            res_acc_reg <= 1'b0;
            res_x_reg   <= 16'sd0;
            res_y_reg   <= 16'sd0;
        end
        unique case (cmd.op)
            OP_READ:
            begin
                if (cmd.step == 5'd0)
                begin
                    sx_reg <= 19'sd0;
                    sy_reg <= 19'sd0;
                end
                else if (cmd.step == 5'd1)
                begin
                    ox_reg    <= rd_x;
                    oy_reg    <= rd_y;
                    res_x_reg <= rd_x;
                    res_y_reg <= rd_y;
                end
                else
                begin
                    sx_reg <= sx_reg + {{3{rd_x[15]}}, rd_x};
                    sy_reg <= sy_reg + {{3{rd_y[15]}}, rd_y};
                end
            end
            OP_THETA:
            begin
                if (cmd.step == 5'd1)
                begin
                    z_reg  <= zn;
                    cx_reg <= {{3{v0x[16]}}, v0x, 16'd0};
                    cy_reg <= {{3{v0y[16]}}, v0y, 16'd0};
                end
            end
            OP_ROT:
            begin
                if (!z_reg[20])
                begin
                    cx_reg <= cx_reg - ddx;
                    cy_reg <= cy_reg + ddy;
                    z_reg  <= z_reg - signed'({5'd0, atan_q16(cmd.step[3:0])});
                end
                else
                begin
                    cx_reg <= cx_reg + ddx;
                    cy_reg <= cy_reg - ddy;
                    z_reg  <= z_reg + signed'({5'd0, atan_q16(cmd.step[3:0])});
                end
            end
            OP_GAIN:
            begin
                unique case (cmd.step)
                    5'd1:    acc_reg <= pe;
                    5'd2:    acc_reg <= acc_reg + (pe <<< 18);
                    5'd3:
                    begin
                        tx_reg  <= rnd_sat(acc_reg);
                        acc_reg <= pe;
                    end
                    5'd4:    acc_reg <= acc_reg + (pe <<< 18);
                    5'd5:    ty_reg  <= rnd_sat(acc_reg);
                    default: acc_reg <= acc_reg;
                endcase
            end
            OP_DOT:
            begin
                unique case (cmd.step)
                    5'd1:    acc_reg <= pe;
                    5'd2:    acc_reg <= acc_reg + pe;
                    5'd3:    de_reg  <= 40'sd0 - acc_reg[39:0];
                    default: acc_reg <= acc_reg;
                endcase
            end
            OP_BETA:
            begin
                unique case (cmd.step)
                    5'd1:    acc_reg <= pe;
                    5'd2:    acc_reg <= acc_reg + (pe <<< 18);
                    5'd3:    xs_reg  <= 64'((acc_u >> XS_R) << XS_L);
                    default: acc_reg <= acc_reg;
                endcase
            end
            OP_LOGI:
            begin
                p_reg    <= pf;
                m_reg    <= 31'({15'd0, rq_reg.draw_accept} << (5'd30 - {1'b0, pf}));
                frac_reg <= 16'd0;
            end
            OP_LOG:
            begin
                if (cmd.step[0])
                begin
                    if (m2[31])
                    begin
                        m_reg    <= m2[31:1];
                        frac_reg <= {frac_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        m_reg    <= m2[30:0];
                        frac_reg <= {frac_reg[14:0], 1'b0};
                    end
                end
            end
            OP_DECIDE:
            begin
                accf_reg <= de_reg[39] || (rq_reg.draw_accept == 16'd0)
                            || (xs_reg <= 64'(prod_reg));
            end
            OP_WRITE:
            begin
                if (stat.is_write)
                begin
                    res_x_reg <= rq_reg.spin_in_x;
                    res_y_reg <= rq_reg.spin_in_y;
                end
                else if (stat.is_update && accf_reg)
                begin
                    res_x_reg   <= tx_reg;
                    res_y_reg   <= ty_reg;
                    res_acc_reg <= 1'b1;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
        if (cmd.load_out)
        begin
            rsp_reg.status     <= res_err_reg;
            rsp_reg.accepted   <= res_acc_reg;
            rsp_reg.spin_out_x <= res_x_reg;
            rsp_reg.spin_out_y <= res_y_reg;
        end
    end

    // configuration and clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= SIDE_RST;
            angle_reg <= ANGLE_RST;
            beta_reg  <= BETA_RST;
            clr_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SIDE:  side_reg  <= cfg_data[SIDE_W-1:0];
                    CFG_ANGLE: angle_reg <= cfg_data;
                    CFG_BETA:  beta_reg  <= cfg_data;
                    default:   side_reg  <= side_reg;
                endcase
            end
            if (cmd.op == OP_CLEAR && !stat.clear_done)
            begin
                clr_reg <= clr_reg + IDXW'(1);
            end
        end
    end
endmodule

@@ sv/xy_spin_metropolis_update.sv @@
// ----------------------------------------------------------------------------
// xy_spin_metropolis_update
// Lattice of XY spins with write, read and Metropolis update commands.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one command item (cmd, site coordinates, spin to write, two draws).
//   rsp  : one result item per command (status, accepted, site spin after).
//   cfg  : register writes, always ready; write only while the block is idle.
// One item is in flight at a time; the next item is taken once the current
//   result sits in the output register. The update time is set by the 16
//   CORDIC iterations, the 16 log2 squaring steps on the shared 32x32
//   multiplier and the seven reads from the single-port store.
// After reset all MAX_SIDE^3 sites of the store (4096 by default) are swept
//   to (1, 0), one site per cycle; req.ready stays low meanwhile.
// A stalled rsp holds its item; the block finishes the next command and
//   waits until the output register is free.
// ----------------------------------------------------------------------------
module xy_spin_metropolis_update #(
    parameter int MAX_SIDE       = xsm_pkg::MAX_SIDE_DEF,
    parameter int SPIN_FRAC_BITS = xsm_pkg::SPIN_FRAC_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    xsm_stream_if.sink          req,
    xsm_stream_if.source        rsp,
    xsm_cfg_if.sink             cfg
);
    import xsm_pkg::*;

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    assign cfg.ready = 1'b1;

    xsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (dcmd),
        .stat      (dstat)
    );

    xsm_dp #(
        .MAX_SIDE       (MAX_SIDE),
        .SPIN_FRAC_BITS (SPIN_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dcmd),
        .stat      (dstat),
        .req_data  (req.data),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .rsp_data  (rsp.data)
    );
endmodule

@@ sv/xsm_checker.sv @@
// ----------------------------------------------------------------------------
// xsm_checker
// Port-level checks on the update block, bound to the top level.
// ----------------------------------------------------------------------------
module xsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        status,
    input logic        accepted,
    input logic [15:0] spin_out_x,
    input logic [15:0] spin_out_y
);
    logic [1:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    assign in_acc  = req_valid && req_ready;
    assign out_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({status, accepted, spin_out_x, spin_out_y}))
        else $error("rsp item changed while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pend_reg != 2'd0)
        else $error("result without a pending command");

    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pend_reg <= 2'd1)
        else $error("command taken with two items outstanding");

    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> !accepted && spin_out_x == 16'd0
            && spin_out_y == 16'd0)
        else $error("error result carries data");
endmodule

bind xy_spin_metropolis_update xsm_checker u_xsm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.data.status),
    .accepted   (rsp.data.accepted),
    .spin_out_x (rsp.data.spin_out_x),
    .spin_out_y (rsp.data.spin_out_y)
);
